FILE: sv/plm_pkg.sv
// Package for the pooled cursor list manager.
// Holds the sequencer state type, operation and status codes and stream widths.
// No dependencies.
`timescale 1ns / 1ps

package plm_pkg;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LOAD, S_NAV, S_NAVR, S_VAL, S_VALR,
    S_INS0, S_INS1, S_INS2, S_INS3, S_INS4,
    S_RM0, S_RM1, S_RM2, S_RM3,
    S_CAT0, S_CAT1, S_FREE, S_WB, S_DONE
  } plm_state_e;

  localparam logic [3:0] OP_CREATE  = 4'd0;
  localparam logic [3:0] OP_FIRST   = 4'd1;
  localparam logic [3:0] OP_LAST    = 4'd2;
  localparam logic [3:0] OP_NEXT    = 4'd3;
  localparam logic [3:0] OP_PREV    = 4'd4;
  localparam logic [3:0] OP_CURRENT = 4'd5;
  localparam logic [3:0] OP_INS_AFT = 4'd6;
  localparam logic [3:0] OP_INS_BEF = 4'd7;
  localparam logic [3:0] OP_APPEND  = 4'd8;
  localparam logic [3:0] OP_PREPEND = 4'd9;
  localparam logic [3:0] OP_REMOVE  = 4'd10;
  localparam logic [3:0] OP_TRIM    = 4'd11;
  localparam logic [3:0] OP_CONCAT  = 4'd12;
  localparam logic [3:0] OP_FREE    = 4'd13;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_ITEM    = 3'd1;
  localparam logic [2:0] ST_POOL_EMPTY = 3'd2;
  localparam logic [2:0] ST_NO_SLOT    = 3'd3;
  localparam logic [2:0] ST_BAD_ID     = 3'd4;

  localparam int IN_W  = 48;
  localparam int OUT_W = 56;

endpackage

FILE: sv/plm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module plm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

FILE: sv/plm_lists.sv
// Register file of per-list descriptors (head, tail, cursor, count, flags).
// One read port, one write port, reset to empty unused lists. Uses plm_pkg.
`timescale 1ns / 1ps

module plm_lists #(
  parameter int LIST_SLOTS = 16,
  parameter int SW = 4,
  parameter type entry_t = logic,
  parameter entry_t RST_VAL = '0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SW-1:0]         raddr_i,
  output entry_t                rdata_o,
  input  logic                  we_i,
  input  logic [SW-1:0]         waddr_i,
  input  entry_t                wdata_i,
  output logic [LIST_SLOTS-1:0] used_o
);
  import plm_pkg::*;

  entry_t tab_q [LIST_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIST_SLOTS; i++) begin
        tab_q[i] <= RST_VAL;
      end
    end else if (we_i && (int'(waddr_i) < LIST_SLOTS)) begin
      tab_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = (int'(raddr_i) < LIST_SLOTS) ? tab_q[raddr_i] : RST_VAL;

  always_comb begin
    for (int i = 0; i < LIST_SLOTS; i++) begin
      used_o[i] = tab_q[i].used;
    end
  end

endmodule

FILE: sv/pooled_cursor_list_manager_unit.sv
// Top level of the pooled cursor list manager: sequencer and node memories.
// Depends on plm_pkg, plm_ram and plm_lists.
//
// Usage: one command transaction enters on the s_axis channel (operation,
// list id, other list id, item) and exactly one result transaction leaves on
// the m_axis channel (status, item valid, item, count, slot).
// A single sequencer drives the next, prev and value node RAMs, one port
// access per cycle each, and the list descriptor file. Each command loads
// its list descriptor, passes through the states of its operation and then
// the completion state, which loads the result register once the output
// register is free. The sequencer returns to idle before the next command
// can be accepted.
// The input is not ready while a command is being worked on. A result that
// waits in the output register does not block the next command; only the
// following result waits until the receiver takes it.
// After reset the block sweeps the pool once to chain all nodes onto the
// free list, with the input not ready.
`timescale 1ns / 1ps

module pooled_cursor_list_manager_unit #(
  parameter int LIST_SLOTS = 16,
  parameter int POOL_NODES = 256,
  parameter int ITEM_BITS  = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // op[3:0], list_id[7:4], other_list_id[11:8], item[43:12], zero fill.
  input  logic [plm_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // status[2:0], item_valid[3], item_out[35:4], count[44:36],
  // slot_out[48:45], zero fill.
  output logic [plm_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import plm_pkg::*;

  localparam int AW    = $clog2(POOL_NODES);
  localparam int PTR_W = $clog2(POOL_NODES + 1);
  localparam int CNT_W = PTR_W;
  localparam int SW    = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
  localparam logic [PTR_W-1:0] NONE = PTR_W'(POOL_NODES);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(POOL_NODES);
  localparam logic [AW-1:0]    LAST_NODE = AW'(POOL_NODES - 1);

  typedef struct packed {
    logic [PTR_W-1:0] hd;
    logic [PTR_W-1:0] tl;
    logic [PTR_W-1:0] cur;
    logic [CNT_W-1:0] cnt;
    logic             oe;
    logic             used;
  } entry_t;

  localparam entry_t ENTRY_RST = '{hd: NONE, tl: NONE, cur: NONE, cnt: '0,
                                   oe: 1'b0, used: 1'b0};

  function automatic logic is_node(input logic [PTR_W-1:0] p);
    return p < NONE;
  endfunction

  function automatic logic [AW-1:0] adr(input logic [PTR_W-1:0] p);
    return p[AW-1:0];
  endfunction

  plm_state_e state_q, state_d;

  logic [3:0]           op_q, op_d, s_q, s_d, t_q, t_d;
  logic [ITEM_BITS-1:0] v_q, v_d, item_q, item_d;
  logic [PTR_W-1:0]     hd_q, hd_d, tl_q, tl_d, cur_q, cur_d;
  logic [PTR_W-1:0]     a_q, a_d, b_q, b_d, nfh_q, nfh_d, fh_q, fh_d;
  logic [PTR_W-1:0]     th_q, th_d, tt_q, tt_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d, tc_q, tc_d, fc_q, fc_d, rcnt_q, rcnt_d;
  logic                 oe_q, oe_d, got_q, got_d, riv_q, riv_d;
  logic [2:0]           st_q, st_d;
  logic [3:0]           rslot_q, rslot_d;
  logic [AW-1:0]        init_q, init_d;

  logic                 m_vld_q;
  logic [OUT_W-1:0]     m_data_q;
  logic                 out_load;

  logic [SW-1:0]           lst_raddr, lst_waddr;
  entry_t                  lst_rd, lst_wdata;
  logic                    lst_we;
  logic [LIST_SLOTS-1:0]   used;

  logic                 nx_we, pv_we, vl_we;
  logic [AW-1:0]        nx_waddr, nx_raddr, pv_waddr, pv_raddr, vl_waddr, vl_raddr;
  logic [PTR_W-1:0]     nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic [ITEM_BITS-1:0] vl_rdata;

  logic [8:0]    s_ext, t_ext;
  logic [SW-1:0] sidx, tidx, free_idx;
  logic          s_ok, t_ok, free_found, reads;
  logic [31:0]   cnt_ext;
  logic [63:0]   item_ext;

  assign s_ext = 9'(s_q);
  assign t_ext = 9'(t_q);
  assign sidx  = s_ext[SW-1:0];
  assign tidx  = t_ext[SW-1:0];
  assign s_ok  = (s_ext < 9'(LIST_SLOTS)) && lst_rd.used;
  assign t_ok  = (t_ext < 9'(LIST_SLOTS)) && lst_rd.used && (t_q != s_q);
  assign reads = (op_q <= OP_CURRENT) || (op_q == OP_REMOVE) || (op_q == OP_TRIM);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = LIST_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  plm_lists #(
    .LIST_SLOTS(LIST_SLOTS), .SW(SW), .entry_t(entry_t), .RST_VAL(ENTRY_RST)
  ) u_lists (
    .clk_i, .rst_ni,
    .raddr_i(lst_raddr), .rdata_o(lst_rd),
    .we_i(lst_we), .waddr_i(lst_waddr), .wdata_i(lst_wdata),
    .used_o(used)
  );

  plm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );

  plm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(pv_raddr), .rdata_o(pv_rdata)
  );

  plm_ram #(.WIDTH(ITEM_BITS), .DEPTH(POOL_NODES)) u_value (
    .clk_i, .we_i(vl_we), .waddr_i(vl_waddr), .wdata_i(v_q),
    .raddr_i(vl_raddr), .rdata_o(vl_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: if (init_q == LAST_NODE) state_d = S_IDLE;
      S_IDLE: if (s_axis_tvalid_i) state_d = S_LOAD;
      S_LOAD: begin
        if (op_q == OP_CREATE) state_d = S_DONE;
        else if (op_q > OP_FREE || !s_ok) state_d = S_DONE;
        else if (op_q == OP_CONCAT) state_d = S_CAT0;
        else if (op_q == OP_FREE) state_d = S_FREE;
        else if (op_q == OP_REMOVE) state_d = S_RM0;
        else state_d = S_NAV;
      end
      S_NAV: begin
        if ((op_q == OP_NEXT) && is_node(cur_q) && (cur_q != tl_q)) begin
          state_d = S_NAVR;
        end else if (((op_q == OP_PREV) || (op_q == OP_INS_BEF)) && is_node(cur_q)
                     && (cur_q != hd_q)) begin
          state_d = S_NAVR;
        end else if (op_q == OP_TRIM) begin
          state_d = S_RM0;
        end else if ((op_q == OP_INS_AFT) || (op_q == OP_INS_BEF) ||
                     (op_q == OP_APPEND) || (op_q == OP_PREPEND)) begin
          state_d = S_INS0;
        end else begin
          state_d = S_VAL;
        end
      end
      S_NAVR: state_d = (op_q == OP_INS_BEF) ? S_INS0 : S_VAL;
      S_VAL:  state_d = is_node(cur_q) ? S_VALR : S_WB;
      S_VALR: state_d = S_WB;
      S_INS0: state_d = ((fc_q == '0) || !is_node(fh_q)) ? S_WB : S_INS1;
      S_INS1: state_d = S_INS2;
      S_INS2: state_d = S_INS3;
      S_INS3: state_d = S_INS4;
      S_INS4: state_d = S_WB;
      S_RM0:  state_d = is_node(cur_q) ? S_RM1 : S_WB;
      S_RM1:  state_d = S_RM2;
      S_RM2:  state_d = S_RM3;
      S_RM3:  state_d = S_WB;
      S_CAT0: state_d = t_ok ? S_CAT1 : S_DONE;
      S_CAT1: state_d = S_WB;
      S_FREE: state_d = S_DONE;
      S_WB:   state_d = S_DONE;
      S_DONE: if (!m_vld_q || m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    op_d = op_q;  s_d = s_q;  t_d = t_q;  v_d = v_q;  item_d = item_q;
    hd_d = hd_q;  tl_d = tl_q;  cur_d = cur_q;  cnt_d = cnt_q;  oe_d = oe_q;
    a_d = a_q;  b_d = b_q;  nfh_d = nfh_q;  fh_d = fh_q;  fc_d = fc_q;
    th_d = th_q;  tt_d = tt_q;  tc_d = tc_q;  got_d = got_q;  riv_d = riv_q;
    st_d = st_q;  rslot_d = rslot_q;  rcnt_d = rcnt_q;  init_d = init_q;
    s_axis_tready_o = 1'b0;
    out_load  = 1'b0;
    lst_raddr = sidx;
    lst_we    = 1'b0;
    lst_waddr = sidx;
    lst_wdata = ENTRY_RST;
    nx_we = 1'b0;  nx_waddr = '0;  nx_wdata = NONE;  nx_raddr = '0;
    pv_we = 1'b0;  pv_waddr = '0;  pv_wdata = NONE;  pv_raddr = '0;
    vl_we = 1'b0;  vl_waddr = '0;  vl_raddr = '0;

    unique case (state_q)
      S_INIT: begin
        nx_we    = 1'b1;
        nx_waddr = init_q;
        nx_wdata = PTR_W'(init_q) + PTR_W'(1);
        pv_we    = 1'b1;
        pv_waddr = init_q;
        init_d   = init_q + AW'(1);
      end
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        op_d = s_axis_tdata_i[3:0];
        s_d  = s_axis_tdata_i[7:4];
        t_d  = s_axis_tdata_i[11:8];
        v_d  = ITEM_BITS'(s_axis_tdata_i[43:12]);
      end
      S_LOAD: begin
        hd_d  = lst_rd.hd;
        tl_d  = lst_rd.tl;
        cur_d = lst_rd.cur;
        cnt_d = lst_rd.cnt;
        oe_d  = lst_rd.oe;
        got_d = 1'b0;
        item_d  = '0;
        riv_d   = 1'b0;
        st_d    = ST_OK;
        rslot_d = s_q;
        rcnt_d  = '0;
        if (op_q == OP_CREATE) begin
          if (free_found) begin
            lst_we    = 1'b1;
            lst_waddr = free_idx;
            lst_wdata = ENTRY_RST;
            lst_wdata.used = 1'b1;
            rslot_d   = 4'(free_idx);
          end else begin
            st_d    = ST_NO_SLOT;
            rslot_d = '0;
          end
        end else if (op_q > OP_FREE || !s_ok) begin
          st_d = ST_BAD_ID;
        end
      end
      S_NAV: begin
        priority case (op_q)
          OP_FIRST: cur_d = hd_q;
          OP_LAST, OP_APPEND, OP_TRIM: cur_d = tl_q;
          OP_NEXT: begin
            if (!is_node(cur_q)) begin
              if (!oe_q) cur_d = hd_q;
            end else if (cur_q == tl_q) begin
              cur_d = NONE;
              oe_d  = 1'b1;
            end else begin
              nx_raddr = adr(cur_q);
            end
          end
          OP_PREV, OP_INS_BEF: begin
            if (!is_node(cur_q)) begin
              if (oe_q) cur_d = tl_q;
            end else if (cur_q == hd_q) begin
              cur_d = NONE;
              oe_d  = 1'b0;
            end else begin
              pv_raddr = adr(cur_q);
            end
          end
          OP_PREPEND: begin
            if (is_node(hd_q)) begin
              cur_d = NONE;
              oe_d  = 1'b0;
            end else if (oe_q) begin
              cur_d = tl_q;
            end else begin
              cur_d = NONE;
            end
          end
          default: ;
        endcase
      end
      S_NAVR: cur_d = (op_q == OP_NEXT) ? nx_rdata : pv_rdata;
      S_VAL: begin
        vl_raddr = adr(cur_q);
        got_d    = is_node(cur_q);
      end
      S_VALR: item_d = vl_rdata;
      S_INS0: begin
        nx_raddr = adr(fh_q);
        if ((fc_q == '0) || !is_node(fh_q)) st_d = ST_POOL_EMPTY;
      end
      S_INS1: begin
        nfh_d    = nx_rdata;
        nx_raddr = adr(cur_q);
      end
      S_INS2: a_d = nx_rdata;
      S_INS3: begin
        nx_we = 1'b1;  nx_waddr = adr(fh_q);
        pv_we = 1'b1;  pv_waddr = adr(fh_q);
        vl_we = 1'b1;  vl_waddr = adr(fh_q);
        if (is_node(cur_q)) begin
          nx_wdata = a_q;
          pv_wdata = cur_q;
        end else if (!oe_q) begin
          nx_wdata = hd_q;
          pv_wdata = NONE;
        end else begin
          nx_wdata = NONE;
          pv_wdata = tl_q;
        end
      end
      S_INS4: begin
        nx_wdata = fh_q;
        pv_wdata = fh_q;
        if (is_node(cur_q)) begin
          nx_we = 1'b1;  nx_waddr = adr(cur_q);
          if (is_node(a_q)) begin
            pv_we = 1'b1;  pv_waddr = adr(a_q);
          end else begin
            tl_d = fh_q;
          end
        end else if (!oe_q) begin
          if (is_node(hd_q)) begin
            pv_we = 1'b1;  pv_waddr = adr(hd_q);
          end else begin
            tl_d = fh_q;
          end
          hd_d = fh_q;
        end else begin
          if (is_node(tl_q)) begin
            nx_we = 1'b1;  nx_waddr = adr(tl_q);
          end else begin
            hd_d = fh_q;
          end
          tl_d = fh_q;
        end
        cur_d = fh_q;
        cnt_d = cnt_q + CNT_W'(1);
        fh_d  = nfh_q;
        fc_d  = fc_q - CNT_W'(1);
      end
      S_RM0: begin
        nx_raddr = adr(cur_q);
        pv_raddr = adr(cur_q);
        vl_raddr = adr(cur_q);
      end
      S_RM1: begin
        a_d    = nx_rdata;
        b_d    = pv_rdata;
        item_d = vl_rdata;
      end
      S_RM2: begin
        nx_wdata = a_q;
        pv_wdata = b_q;
        if (is_node(b_q)) begin
          nx_we = 1'b1;  nx_waddr = adr(b_q);
        end else begin
          hd_d = a_q;
        end
        if (is_node(a_q)) begin
          pv_we = 1'b1;  pv_waddr = adr(a_q);
        end else begin
          tl_d = b_q;
          oe_d = 1'b1;
        end
      end
      S_RM3: begin
        nx_we = 1'b1;  nx_waddr = adr(cur_q);  nx_wdata = fh_q;
        pv_we = 1'b1;  pv_waddr = adr(cur_q);  pv_wdata = NONE;
        fh_d  = cur_q;
        fc_d  = fc_q + CNT_W'(1);
        cur_d = a_q;
        if (cnt_q != '0) cnt_d = cnt_q - CNT_W'(1);
        got_d = 1'b1;
      end
      S_CAT0: begin
        lst_raddr = tidx;
        th_d = lst_rd.hd;
        tt_d = lst_rd.tl;
        tc_d = lst_rd.cnt;
        if (!t_ok) st_d = ST_BAD_ID;
      end
      S_CAT1: begin
        lst_we    = 1'b1;
        lst_waddr = tidx;
        nx_waddr  = adr(tl_q);
        nx_wdata  = th_q;
        pv_waddr  = adr(th_q);
        pv_wdata  = tl_q;
        if (tc_q != '0) begin
          if ((cnt_q == '0) || !is_node(tl_q)) begin
            hd_d  = th_q;
            tl_d  = tt_q;
            cnt_d = tc_q;
          end else begin
            nx_we = 1'b1;
            pv_we = is_node(th_q);
            tl_d  = tt_q;
            cnt_d = cnt_q + tc_q;
          end
        end
      end
      S_FREE: begin
        lst_we = 1'b1;
        if ((cnt_q != '0) && is_node(hd_q) && is_node(tl_q)) begin
          nx_we    = 1'b1;
          nx_waddr = adr(tl_q);
          nx_wdata = fh_q;
          fh_d     = hd_q;
          fc_d     = fc_q + cnt_q;
        end
      end
      S_WB: begin
        lst_we    = 1'b1;
        lst_wdata = '{hd: hd_q, tl: tl_q, cur: cur_q, cnt: cnt_q, oe: oe_q, used: 1'b1};
        rcnt_d    = cnt_q;
        riv_d     = reads && got_q;
        if (reads && !got_q) begin
          st_d   = ST_NO_ITEM;
          item_d = '0;
        end else if (!reads) begin
          item_d = '0;
        end
      end
      S_DONE: out_load = !m_vld_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= '0;
      fh_q    <= '0;
      fc_q    <= FULL;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      fh_q    <= fh_d;
      fc_q    <= fc_d;
      if (out_load) m_vld_q <= 1'b1;
      else if (m_axis_tready_i) m_vld_q <= 1'b0;
    end
  end

  assign cnt_ext  = 32'(rcnt_q);
  assign item_ext = 64'(item_q);

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  s_q <= s_d;  t_q <= t_d;  v_q <= v_d;  item_q <= item_d;
    hd_q <= hd_d;  tl_q <= tl_d;  cur_q <= cur_d;  cnt_q <= cnt_d;  oe_q <= oe_d;
    a_q <= a_d;  b_q <= b_d;  nfh_q <= nfh_d;
    th_q <= th_d;  tt_q <= tt_d;  tc_q <= tc_d;  got_q <= got_d;  riv_q <= riv_d;
    st_q <= st_d;  rslot_q <= rslot_d;  rcnt_q <= rcnt_d;
    if (out_load) begin
      m_data_q <= {7'b0, rslot_q, cnt_ext[8:0], item_ext[31:0], riv_q, st_q};
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;

  a_free_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FULL) else $error("free node count exceeds the pool size");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == S_LOAD))
    else $error("accepted command did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside the completion step");

endmodule

FILE: verif/tb.sv
// Testbench for the pooled cursor list manager unit.
// Drives command transactions, predicts each result with a behavioral list model
// and checks every result transaction. Depends on plm_pkg and the unit RTL.
`timescale 1ns / 1ps

class list_result_board;
  localparam int NSLOT = 16;
  localparam int NNODE = 256;
  localparam int NIL = 256;

  int unsigned nxt[NNODE];
  int unsigned prv[NNODE];
  bit [31:0] val[NNODE];
  int unsigned head[NSLOT];
  int unsigned tail[NSLOT];
  int unsigned cnt[NSLOT];
  int unsigned cur[NSLOT];
  bit off_end[NSLOT];
  bit used[NSLOT];
  int unsigned fhead;
  int unsigned fcount;
  bit [48:0] pending[$];
  int errors;

  function new();
    errors = 0;
    for (int i = 0; i < NNODE; i++) begin
      nxt[i] = i + 1;
      prv[i] = NIL;
      val[i] = '0;
    end
    for (int i = 0; i < NSLOT; i++) drop_list(i);
    fhead = 0;
    fcount = NNODE;
  endfunction

  function void drop_list(int unsigned s);
    head[s] = NIL;
    tail[s] = NIL;
    cnt[s] = 0;
    cur[s] = NIL;
    off_end[s] = 0;
    used[s] = 0;
  endfunction

  function bit to_first(int unsigned s);
    cur[s] = head[s];
    return head[s] != NIL;
  endfunction

  function bit to_last(int unsigned s);
    cur[s] = tail[s];
    return tail[s] != NIL;
  endfunction

  function bit step_fwd(int unsigned s);
    int unsigned c;
    c = cur[s];
    if (c >= NIL) begin
      if (!off_end[s]) return to_first(s);
      return 0;
    end
    if (c == tail[s]) begin
      cur[s] = NIL;
      off_end[s] = 1;
      return 0;
    end
    cur[s] = nxt[c];
    return nxt[c] < NIL;
  endfunction

  function bit step_back(int unsigned s);
    int unsigned c;
    c = cur[s];
    if (c >= NIL) begin
      if (off_end[s]) return to_last(s);
      return 0;
    end
    if (c == head[s]) begin
      cur[s] = NIL;
      off_end[s] = 0;
      return 0;
    end
    cur[s] = prv[c];
    return prv[c] < NIL;
  endfunction

  function bit link_after(int unsigned s, bit [31:0] v);
    int unsigned n, c, a;
    if (fcount == 0 || fhead >= NIL) return 0;
    n = fhead;
    fhead = nxt[n];
    fcount--;
    c = cur[s];
    if (c >= NIL) begin
      if (!off_end[s]) begin
        nxt[n] = head[s];
        prv[n] = NIL;
        if (head[s] < NIL) prv[head[s]] = n;
        else tail[s] = n;
        head[s] = n;
      end else begin
        nxt[n] = NIL;
        prv[n] = tail[s];
        if (tail[s] < NIL) nxt[tail[s]] = n;
        else head[s] = n;
        tail[s] = n;
      end
    end else begin
      a = nxt[c];
      nxt[n] = a;
      prv[n] = c;
      nxt[c] = n;
      if (a < NIL) prv[a] = n;
      else tail[s] = n;
    end
    val[n] = v;
    cur[s] = n;
    cnt[s]++;
    return 1;
  endfunction

  function bit unlink_cur(int unsigned s, output bit [31:0] v);
    int unsigned c, b, a;
    c = cur[s];
    v = '0;
    if (c >= NIL) return 0;
    b = prv[c];
    a = nxt[c];
    if (b < NIL) nxt[b] = a;
    else head[s] = a;
    if (a < NIL) prv[a] = b;
    else begin
      tail[s] = b;
      off_end[s] = 1;
    end
    v = val[c];
    nxt[c] = fhead;
    prv[c] = NIL;
    fhead = c;
    fcount++;
    cur[s] = a;
    if (cnt[s] > 0) cnt[s]--;
    return 1;
  endfunction

  function void note_command(bit [3:0] op, bit [3:0] s, bit [3:0] t, bit [31:0] v);
    bit [2:0] st;
    bit iv, got, reads, dummy;
    bit [31:0] item;
    bit [8:0] c9;
    bit [3:0] slot;
    st = plm_pkg::ST_OK;
    iv = 0;
    got = 0;
    reads = 0;
    item = '0;
    c9 = '0;
    slot = s;
    if (op == plm_pkg::OP_CREATE) begin
      slot = 0;
      st = plm_pkg::ST_NO_SLOT;
      for (int i = 0; i < NSLOT; i++) begin
        if (!used[i]) begin
          drop_list(i);
          used[i] = 1;
          slot = 4'(i);
          st = plm_pkg::ST_OK;
          break;
        end
      end
    end else if (op > plm_pkg::OP_FREE || !used[s]) begin
      st = plm_pkg::ST_BAD_ID;
    end else if (op == plm_pkg::OP_CONCAT) begin
      if (!used[t] || t == s) begin
        st = plm_pkg::ST_BAD_ID;
      end else begin
        if (cnt[t] != 0) begin
          if (cnt[s] == 0 || tail[s] >= NIL) begin
            head[s] = head[t];
            tail[s] = tail[t];
            cnt[s] = cnt[t];
          end else begin
            nxt[tail[s]] = head[t];
            if (head[t] < NIL) prv[head[t]] = tail[s];
            tail[s] = tail[t];
            cnt[s] += cnt[t];
          end
        end
        drop_list(t);
        c9 = 9'(cnt[s]);
      end
    end else if (op == plm_pkg::OP_FREE) begin
      if (cnt[s] != 0 && head[s] < NIL && tail[s] < NIL) begin
        nxt[tail[s]] = fhead;
        fhead = head[s];
        fcount += cnt[s];
      end
      drop_list(s);
    end else begin
      reads = op <= plm_pkg::OP_CURRENT || op == plm_pkg::OP_REMOVE ||
              op == plm_pkg::OP_TRIM;
      case (op)
        plm_pkg::OP_FIRST: got = to_first(s);
        plm_pkg::OP_LAST: got = to_last(s);
        plm_pkg::OP_NEXT: got = step_fwd(s);
        plm_pkg::OP_PREV: got = step_back(s);
        plm_pkg::OP_CURRENT: got = cur[s] < NIL;
        plm_pkg::OP_INS_AFT:
          st = link_after(s, v) ? plm_pkg::ST_OK : plm_pkg::ST_POOL_EMPTY;
        plm_pkg::OP_INS_BEF: begin
          dummy = step_back(s);
          st = link_after(s, v) ? plm_pkg::ST_OK : plm_pkg::ST_POOL_EMPTY;
        end
        plm_pkg::OP_APPEND: begin
          dummy = to_last(s);
          st = link_after(s, v) ? plm_pkg::ST_OK : plm_pkg::ST_POOL_EMPTY;
        end
        plm_pkg::OP_PREPEND: begin
          dummy = to_first(s);
          dummy = step_back(s);
          st = link_after(s, v) ? plm_pkg::ST_OK : plm_pkg::ST_POOL_EMPTY;
        end
        plm_pkg::OP_REMOVE: got = unlink_cur(s, item);
        default: begin
          dummy = to_last(s);
          got = unlink_cur(s, item);
        end
      endcase
      if (reads) begin
        if (got) begin
          if (op <= plm_pkg::OP_CURRENT) item = val[cur[s]];
          iv = 1;
        end else begin
          st = plm_pkg::ST_NO_ITEM;
          item = '0;
        end
      end
      c9 = 9'(cnt[s]);
    end
    pending.push_back({slot, c9, item, iv, st});
  endfunction

  function void check_result(bit [55:0] d);
    bit [48:0] e;
    if (pending.size() == 0) begin
      $error("unexpected result transaction %h", d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (d[2:0] !== e[2:0]) begin
      $error("status expected %0d actual %0d", e[2:0], d[2:0]);
      errors++;
    end
    if (d[3] !== e[3]) begin
      $error("item_valid expected %0d actual %0d", e[3], d[3]);
      errors++;
    end
    if (d[35:4] !== e[35:4]) begin
      $error("item_out expected %h actual %h", e[35:4], d[35:4]);
      errors++;
    end
    if (d[44:36] !== e[44:36]) begin
      $error("count expected %0d actual %0d", e[44:36], d[44:36]);
      errors++;
    end
    if (d[48:45] !== e[48:45]) begin
      $error("slot_out expected %0d actual %0d", e[48:45], d[48:45]);
      errors++;
    end
  endfunction
endclass

module tb;
  import plm_pkg::*;

  localparam int WATCHDOG = 5000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  list_result_board board;
  bit calm_tail = 0;
  bit hold_sink = 0;
  int idle_cycles = 0;
  int sent = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  pooled_cursor_list_manager_unit u_top (.*);

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      board.note_command(s_axis_tdata_i[3:0], s_axis_tdata_i[7:4],
                         s_axis_tdata_i[11:8], s_axis_tdata_i[43:12]);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result side: random stall bursts, or a long hold while hold_sink is set.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_sink) m_axis_tready_i <= 0;
      else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 0;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(posedge clk_i);
      end else m_axis_tready_i <= 1;
    end
  end

  // The valid flag stays high after an accepted transaction; the caller drops it
  // once the last command of a sequence has gone.
  task automatic send_cmd(bit [3:0] op, bit [3:0] s, bit [3:0] t, bit [31:0] v);
    int n;
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= {4'b0, v, t, s, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
  endtask

  function automatic bit [3:0] pick_slot();
    bit [3:0] s;
    for (int k = 0; k < 4; k++) begin
      s = 4'($urandom_range(0, 15));
      if (board.used[s]) return s;
    end
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic random_cmd();
    int r;
    bit [3:0] op;
    r = $urandom_range(0, 99);
    if (r < 4) op = OP_CREATE;
    else if (r < 40) op = 4'($urandom_range(OP_INS_AFT, OP_PREPEND));
    else if (r < 75) op = 4'($urandom_range(OP_FIRST, OP_CURRENT));
    else if (r < 88) op = 4'($urandom_range(OP_REMOVE, OP_TRIM));
    else if (r < 93) op = OP_CONCAT;
    else if (r < 97) op = OP_FREE;
    else op = 4'($urandom_range(14, 15));
    send_cmd(op, pick_slot(), pick_slot(), $urandom());
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: bad ids, empty navigation, extremes of items, each operation.
    send_cmd(OP_FIRST, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_CREATE, 4'd15, 4'd0, 32'd0);
    send_cmd(OP_NEXT, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_REMOVE, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_TRIM, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_APPEND, 4'd0, 4'd0, 32'hFFFFFFFF);
    send_cmd(OP_PREPEND, 4'd0, 4'd0, 32'h0);
    send_cmd(OP_INS_AFT, 4'd0, 4'd0, 32'hA5A5A5A5);
    send_cmd(OP_INS_BEF, 4'd0, 4'd0, 32'h5A5A5A5A);
    send_cmd(OP_FIRST, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_LAST, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_PREV, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_CURRENT, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_CREATE, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_APPEND, 4'd1, 4'd0, 32'h12345678);
    send_cmd(OP_CONCAT, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_CONCAT, 4'd0, 4'd1, 32'd0);
    send_cmd(OP_REMOVE, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_TRIM, 4'd0, 4'd0, 32'd0);
    send_cmd(4'd14, 4'd0, 4'd0, 32'd0);
    send_cmd(4'd15, 4'd0, 4'd0, 32'd0);
    send_cmd(OP_FREE, 4'd0, 4'd0, 32'd0);
    for (int i = 0; i < 17; i++) send_cmd(OP_CREATE, 4'd0, 4'd0, 32'd0);
    // Exhaust the pool so inserts report an empty pool, then free it back.
    for (int i = 0; i < 258; i++) send_cmd(OP_APPEND, 4'd3, 4'd0, $urandom());
    send_cmd(OP_PREPEND, 4'd4, 4'd0, 32'd1);
    send_cmd(OP_INS_BEF, 4'd4, 4'd0, 32'd2);
    send_cmd(OP_FREE, 4'd3, 4'd0, 32'd0);
    for (int i = 4; i < 16; i++) send_cmd(OP_FREE, i[3:0], 4'd0, 32'd0);
    for (int i = 0; i < 60; i++) random_cmd();
    // Long receiver hold-off while commands keep coming.
    hold_sink = 1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_sink = 0;
      end
      begin
        for (int i = 0; i < 10; i++) random_cmd();
        s_axis_tvalid_i <= 0;
      end
    join
    for (int i = 0; i < 40; i++) random_cmd();
    calm_tail = 1;
    for (int i = 0; i < 30; i++) random_cmd();
    s_axis_tvalid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
